[rtl/hufd_pkg.sv]
// hufd_pkg: shared types and constants of the huffman table decoder
// node word layout, request codes and the request bundle to the walker
// no dependencies
package hufd_pkg;

    localparam int SYMBOL_BITS = 8;
    localparam int MAX_NODES   = 512;

    localparam int IDX_W      = 9;
    localparam int BYTE_BITS  = 8;
    localparam int VBITS_W    = 4;
    localparam int SYM_W      = (SYMBOL_BITS < 8) ? SYMBOL_BITS : 8;
    localparam int NODE_DEPTH = (MAX_NODES < 512) ? MAX_NODES : 512;
    localparam int ADDR_W     = $clog2(NODE_DEPTH);
    localparam int NODE_W     = 1 + 2 * IDX_W + SYM_W;

    localparam logic [IDX_W-1:0] ROOT_IDX = '0;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_DECODE = 1'b1
    } t_req_type;

    typedef struct packed {
        logic             leaf;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [SYM_W-1:0] sym;
    } t_node;

    typedef struct packed {
        logic               load;
        logic               decode;
        logic [7:0]         code_byte;
        logic [VBITS_W-1:0] valid_bits;
    } t_req;

endpackage

[rtl/hufd_ram.sv]
// hufd_ram: generic single-port-write, single-port-read ram
// registered read data, no dependencies
module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/hufd_walker.sv]
// hufd_walker: tree walk sequencer, one code bit per node-table read
// keeps root and current node copies, holds back one symbol to mark the last
// depends on hufd_pkg
module hufd_walker
    import hufd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req             i_req,
    input  t_node            i_rd_node,
    output logic [IDX_W-1:0] o_rd_idx,
    output logic             o_busy,
    output logic             o_valid,
    output logic [7:0]       o_symbol,
    output logic             o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_FILL_CAP,
        S_WALK,
        S_FLUSH
    } t_state;

    t_state             r_state,     n_state;
    logic [7:0]         r_byte,      n_byte;
    logic [VBITS_W-1:0] r_left,      n_left;
    logic               r_wait,      n_wait;
    logic [IDX_W-1:0]   r_nxt_idx,   n_nxt_idx;
    logic [IDX_W-1:0]   r_cur_idx,   n_cur_idx;
    t_node              r_cur_node,  n_cur_node;
    logic               r_cur_ok,    n_cur_ok;
    t_node              r_root_node, n_root_node;
    logic               r_root_ok,   n_root_ok;
    logic               r_pend_ok,   n_pend_ok;
    logic [SYM_W-1:0]   r_pend_sym,  n_pend_sym;
    logic               r_valid,     n_valid;
    logic [7:0]         r_symbol,    n_symbol;
    logic               r_last,      n_last;

    t_node              c_node;
    logic [IDX_W-1:0]   c_idx;
    logic [IDX_W-1:0]   c_child;
    logic               c_res_emit;
    logic               c_emit;
    logic [SYM_W-1:0]   c_emit_sym;

    always_comb begin
        n_state     = r_state;
        n_byte      = r_byte;
        n_left      = r_left;
        n_wait      = r_wait;
        n_nxt_idx   = r_nxt_idx;
        n_cur_idx   = r_cur_idx;
        n_cur_node  = r_cur_node;
        n_cur_ok    = r_cur_ok;
        n_root_node = r_root_node;
        n_root_ok   = r_root_ok;
        n_pend_ok   = r_pend_ok;
        n_pend_sym  = r_pend_sym;
        n_valid     = 1'b0;
        n_symbol    = r_symbol;
        n_last      = r_last;
        o_rd_idx    = r_nxt_idx;
        c_node      = r_cur_node;
        c_idx       = r_cur_idx;
        c_child     = r_cur_node.left;
        c_res_emit  = 1'b0;
        c_emit      = 1'b0;
        c_emit_sym  = r_cur_node.sym;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.load) begin
                    // table contents may have changed
                    n_cur_ok  = 1'b0;
                    n_root_ok = 1'b0;
                end else if (i_req.decode && (i_req.valid_bits != '0)) begin
                    n_byte  = i_req.code_byte;
                    n_left  = (i_req.valid_bits > VBITS_W'(BYTE_BITS)) ?
                              VBITS_W'(BYTE_BITS) : i_req.valid_bits;
                    n_wait  = 1'b0;
                    n_state = (r_root_ok && r_cur_ok) ? S_WALK : S_FILL;
                end
            end
            S_FILL: begin
                o_rd_idx = r_root_ok ? r_cur_idx : ROOT_IDX;
                n_state  = S_FILL_CAP;
            end
            S_FILL_CAP: begin
                if (!r_root_ok) begin
                    n_root_node = i_rd_node;
                    n_root_ok   = 1'b1;
                    n_state     = r_cur_ok ? S_WALK : S_FILL;
                end else begin
                    n_cur_node = i_rd_node;
                    n_cur_ok   = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                // resolve the child read issued last cycle
                if (r_wait) begin
                    if (i_rd_node.leaf) begin
                        c_res_emit = 1'b1;
                        c_emit     = 1'b1;
                        c_emit_sym = i_rd_node.sym;
                        c_node     = r_root_node;
                        c_idx      = ROOT_IDX;
                    end else begin
                        c_node = i_rd_node;
                        c_idx  = r_nxt_idx;
                    end
                end
                n_cur_node = c_node;
                n_cur_idx  = c_idx;
                n_wait     = 1'b0;
                c_child    = r_byte[7] ? c_node.right : c_node.left;
                // a leaf root right after a leaf hit consumes no code bit yet
                if ((r_left != '0) && !(c_res_emit && r_root_node.leaf)) begin
                    n_byte = {r_byte[6:0], 1'b0};
                    n_left = r_left - VBITS_W'(1);
                    if (c_node.leaf) begin
                        c_emit     = 1'b1;
                        c_emit_sym = c_node.sym;
                        n_cur_node = r_root_node;
                        n_cur_idx  = ROOT_IDX;
                    end else begin
                        o_rd_idx  = c_child;
                        n_nxt_idx = c_child;
                        n_wait    = 1'b1;
                    end
                end
                if ((n_left == '0) && !n_wait) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (r_pend_ok) begin
                    n_valid   = 1'b1;
                    n_symbol  = 8'(r_pend_sym);
                    n_last    = 1'b1;
                    n_pend_ok = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a new symbol releases the held one as not last
        if (c_emit) begin
            if (r_pend_ok) begin
                n_valid  = 1'b1;
                n_symbol = 8'(r_pend_sym);
                n_last   = 1'b0;
            end
            n_pend_ok  = 1'b1;
            n_pend_sym = c_emit_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_left    <= '0;
            r_wait    <= 1'b0;
            r_cur_idx <= ROOT_IDX;
            r_cur_ok  <= 1'b0;
            r_root_ok <= 1'b0;
            r_pend_ok <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_left    <= n_left;
            r_wait    <= n_wait;
            r_cur_idx <= n_cur_idx;
            r_cur_ok  <= n_cur_ok;
            r_root_ok <= n_root_ok;
            r_pend_ok <= n_pend_ok;
            r_valid   <= n_valid;
        end
        r_byte      <= n_byte;
        r_nxt_idx   <= n_nxt_idx;
        r_cur_node  <= n_cur_node;
        r_root_node <= n_root_node;
        r_pend_sym  <= n_pend_sym;
        r_symbol    <= n_symbol;
        r_last      <= n_last;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;

endmodule

[rtl/huffman_table_decoder_top.sv]
// huffman_table_decoder_top: huffman decoder walking a code tree in a node table
// node table ram, load write path and tree walk sequencer
// depends on hufd_pkg, hufd_ram, hufd_walker
//
// A request is taken when start is high and busy is low. A load request writes
// one node in the cycle it is taken and never raises busy. A decode request
// with N leading bits (1 to 8) raises busy while it makes one node-table read
// per code bit, resolves the last read and sends the held-back final symbol;
// a leaf hit followed by a root that is itself a leaf holds the walk back once.
// The first decode after any load first re-reads the root and the current
// node. The single read port of the node table paces the walk. Symbols come
// out on o_symbol_out with o_valid high for one cycle each; they cannot be
// stalled. o_last_in_run marks the final symbol of a code byte; a byte that
// reaches no leaf gives no symbol. The walk position carries across code
// bytes.
module huffman_table_decoder_top
    import hufd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic [IDX_W-1:0]   i_node_index,
    input  logic               i_is_leaf,
    input  logic [IDX_W-1:0]   i_left_child,
    input  logic [IDX_W-1:0]   i_right_child,
    input  logic [7:0]         i_leaf_symbol,
    input  logic [7:0]         i_code_byte,
    input  logic [VBITS_W-1:0] i_valid_bits,
    output logic               o_valid,
    output logic [7:0]         o_symbol_out,
    output logic               o_last_in_run
);

    logic             w_accept;
    t_req             w_req;
    logic             w_we;
    t_node            w_wnode;
    logic [IDX_W-1:0] w_rd_idx;
    logic [NODE_W-1:0] w_ram_q;
    t_node            w_rd_node;
    logic             r_rd_oob, n_rd_oob;

    assign w_accept = start && !busy;

    assign w_req.load       = w_accept && (i_req_type == REQ_LOAD);
    assign w_req.decode     = w_accept && (i_req_type == REQ_DECODE);
    assign w_req.code_byte  = i_code_byte;
    assign w_req.valid_bits = i_valid_bits;

    // writes past the table are dropped
    assign w_we = w_req.load &&
                  ({1'b0, i_node_index} < (IDX_W + 1)'(NODE_DEPTH));

    assign w_wnode.leaf  = i_is_leaf;
    assign w_wnode.left  = i_left_child;
    assign w_wnode.right = i_right_child;
    assign w_wnode.sym   = i_leaf_symbol[SYM_W-1:0];

    hufd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_node_index[ADDR_W-1:0]),
        .i_wdata (w_wnode),
        .i_raddr (w_rd_idx[ADDR_W-1:0]),
        .o_rdata (w_ram_q)
    );

    // reads past the table return an inner node with zero children
    assign n_rd_oob = ({1'b0, w_rd_idx} >= (IDX_W + 1)'(NODE_DEPTH));

    always_ff @(posedge i_clk) begin
        r_rd_oob <= n_rd_oob;
    end

    assign w_rd_node = r_rd_oob ? t_node'('0) : t_node'(w_ram_q);

    hufd_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_rd_node (w_rd_node),
        .o_rd_idx  (w_rd_idx),
        .o_busy    (busy),
        .o_valid   (o_valid),
        .o_symbol  (o_symbol_out),
        .o_last    (o_last_in_run)
    );

endmodule

[rtl/hufd_checker.sv]
// hufd_checker: port-level checks of huffman_table_decoder_top
// bound to the top level, depends on hufd_pkg
module hufd_checker
    import hufd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_req_type,
    input logic [VBITS_W-1:0] i_valid_bits,
    input logic               o_valid,
    input logic               o_last_in_run
);

    // loads finish in the transfer cycle
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_LOAD)) |=> !busy)
        else $error("load request raised busy");

    // an empty code byte is dropped at once
    a_empty_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_DECODE) && (i_valid_bits == '0))
        |=> !busy)
        else $error("empty decode request raised busy");

    // more symbols follow, so the decode is still running
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_in_run) |-> busy)
        else $error("non-final symbol while idle");

    // last symbol of a run is never directly followed by another
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_in_run) |=> !o_valid)
        else $error("symbol right after final symbol");

    // every symbol comes out of a running decode
    a_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("symbol without a running decode");

endmodule

bind huffman_table_decoder_top hufd_checker u_hufd_checker (.*);
